// ----- rtl/gsbb_pkg.sv -----
// shared types and constants for the greedy size-balanced binning core
// no dependencies
package gsbb_pkg;

    localparam int ID_W      = 16;
    localparam int SIZE_W    = 48;
    localparam int LOAD_W    = 54;
    localparam int CFG_W     = 5;
    localparam int BIN_OUT_W = 4;

    localparam logic [CFG_W-1:0] BIN_COUNT_RST = CFG_W'(2);

    typedef struct packed {
        logic              vld;
        logic [SIZE_W-1:0] size;
        logic [ID_W-1:0]   id;
    } t_item;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_item_ctl;

    typedef struct packed {
        logic init;
        logic step;
    } t_bin_ctl;

endpackage

// ----- rtl/gsbb_item_cell.sv -----
// one cell of the sorting chain: holds one item, largest size toward the head
// depends on gsbb_pkg
module gsbb_item_cell
    import gsbb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_item_ctl i_ctl,
    input  t_item     i_new,
    input  t_item     i_left,
    input  logic      i_left_keep,
    input  t_item     i_right,
    output t_item     o_data,
    output logic      o_keep
);

    t_item r_data;
    t_item n_data;

    // equal sizes stay ahead of the new item
    assign o_keep = r_data.vld && (r_data.size >= i_new.size);
    assign o_data = r_data;

    always_comb begin
        n_data = r_data;
        priority if (i_ctl.shift) begin
            n_data = i_right;
        end else if (i_ctl.ins) begin
            priority if (o_keep) begin
                n_data = r_data;
            end else if (i_left_keep) begin
                n_data = i_new;
            end else begin
                n_data = i_left;
            end
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.vld <= 1'b0;
        end else begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/gsbb_bin_cell.sv -----
// one cell of the bin chain: bins kept ordered by load then index, least at the head
// depends on gsbb_pkg
module gsbb_bin_cell
    import gsbb_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_bin_ctl          i_ctl,
    input  logic              i_init_vld,
    input  logic [IDX_W-1:0]  i_init_idx,
    input  logic [LOAD_W-1:0] i_key_load,
    input  logic [IDX_W-1:0]  i_key_idx,
    input  logic              i_left_lt,
    input  logic              i_right_vld,
    input  logic [LOAD_W-1:0] i_right_load,
    input  logic [IDX_W-1:0]  i_right_idx,
    output logic              o_vld,
    output logic [LOAD_W-1:0] o_load,
    output logic [IDX_W-1:0]  o_idx,
    output logic              o_lt
);

    logic              r_vld;
    logic [LOAD_W-1:0] r_load;
    logic [IDX_W-1:0]  r_idx;
    logic              n_vld;
    logic [LOAD_W-1:0] n_load;
    logic [IDX_W-1:0]  n_idx;

    // right neighbor sorts before the re-inserted head bin
    assign o_lt = i_right_vld &&
                  ((i_right_load < i_key_load) ||
                   ((i_right_load == i_key_load) && (i_right_idx < i_key_idx)));

    assign o_vld  = r_vld;
    assign o_load = r_load;
    assign o_idx  = r_idx;

    always_comb begin
        n_vld  = r_vld;
        n_load = r_load;
        n_idx  = r_idx;
        priority if (i_ctl.init) begin
            n_vld  = i_init_vld;
            n_load = '0;
            n_idx  = i_init_idx;
        end else if (i_ctl.step) begin
            priority if (o_lt) begin
                n_vld  = i_right_vld;
                n_load = i_right_load;
                n_idx  = i_right_idx;
            end else if (i_left_lt) begin
                n_vld  = 1'b1;
                n_load = i_key_load;
                n_idx  = i_key_idx;
            end else begin
                n_vld  = r_vld;
            end
        end else begin
            n_vld  = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld  <= n_vld;
            r_load <= n_load;
            r_idx  <= n_idx;
        end
    end

endmodule

// ----- rtl/greedy_size_balanced_binning_core.sv -----
// greedy size-balanced binning core: loads one request per cycle into a sorting chain;
// after the request marked last, emits one result per held item, one per cycle when
// the output is not stalled (the state moves to assign, then the first result is registered)
// no request is taken while a set is being assigned. synchronous active-low reset empties
// both chains, clears the item count and sets bin_count to 2
module greedy_size_balanced_binning_core
    import gsbb_pkg::*;
#(
    parameter int MAX_ITEMS = 64,
    parameter int MAX_BINS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ID_W-1:0]      i_item_id,
    input  logic [SIZE_W-1:0]    i_item_size,
    input  logic                 i_last_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [ID_W-1:0]      o_out_item_id,
    output logic [BIN_OUT_W-1:0] o_bin_index,
    output logic                 o_last_result
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W = $clog2(MAX_BINS);

    localparam logic ST_LOAD   = 1'b0;
    localparam logic ST_ASSIGN = 1'b1;

    logic                 r_state;
    logic                 n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [CFG_W-1:0]     r_bin_count;
    logic                 r_out_vld;
    logic [ID_W-1:0]      r_out_id;
    logic [BIN_OUT_W-1:0] r_out_bin;
    logic                 r_out_last;

    logic      w_in_fire;
    logic      w_full;
    logic      w_step;
    t_item_ctl w_item_ctl;
    t_bin_ctl  w_bin_ctl;
    t_item     w_new;

    t_item w_item      [MAX_ITEMS];
    logic  w_item_keep [MAX_ITEMS];

    logic              w_bin_vld  [MAX_BINS];
    logic [LOAD_W-1:0] w_bin_load [MAX_BINS];
    logic [IDX_W-1:0]  w_bin_idx  [MAX_BINS];
    logic              w_bin_lt   [MAX_BINS];
    logic [LOAD_W-1:0] w_key_load;

    assign o_in_ready = (r_state == ST_LOAD);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(MAX_ITEMS));
    assign w_step     = (r_state == ST_ASSIGN) && (!r_out_vld || i_out_ready);

    assign w_item_ctl.ins   = w_in_fire && !w_full;
    assign w_item_ctl.shift = w_step;
    assign w_bin_ctl.init   = w_in_fire && i_last_item;
    assign w_bin_ctl.step   = w_step;

    assign w_new.vld  = 1'b1;
    assign w_new.size = i_item_size;
    assign w_new.id   = i_item_id;

    assign w_key_load = w_bin_load[0] + LOAD_W'(w_item[0].size);

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_item
        t_item w_left;
        logic  w_left_keep;
        t_item w_right;

        if (g == 0) begin : g_head
            assign w_left      = w_new;
            assign w_left_keep = 1'b1;
        end else begin : g_body
            assign w_left      = w_item[g-1];
            assign w_left_keep = w_item_keep[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_item[g+1];
        end

        gsbb_item_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_item_ctl),
            .i_new       (w_new),
            .i_left      (w_left),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_data      (w_item[g]),
            .o_keep      (w_item_keep[g])
        );
    end

    for (genvar g = 0; g < MAX_BINS; g++) begin : g_bin
        logic              w_init_vld;
        logic              w_left_lt;
        logic              w_right_vld;
        logic [LOAD_W-1:0] w_right_load;
        logic [IDX_W-1:0]  w_right_idx;

        // bin_count of zero or one acts as one bin, above MAX_BINS saturates
        assign w_init_vld = (g == 0) || (32'(g) < 32'(r_bin_count));

        if (g == 0) begin : g_head
            assign w_left_lt = 1'b1;
        end else begin : g_body
            assign w_left_lt = w_bin_lt[g-1];
        end

        if (g == MAX_BINS - 1) begin : g_tail
            assign w_right_vld  = 1'b0;
            assign w_right_load = '0;
            assign w_right_idx  = '0;
        end else begin : g_mid
            assign w_right_vld  = w_bin_vld[g+1];
            assign w_right_load = w_bin_load[g+1];
            assign w_right_idx  = w_bin_idx[g+1];
        end

        gsbb_bin_cell #(
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_bin_ctl),
            .i_init_vld   (w_init_vld),
            .i_init_idx   (IDX_W'(g)),
            .i_key_load   (w_key_load),
            .i_key_idx    (w_bin_idx[0]),
            .i_left_lt    (w_left_lt),
            .i_right_vld  (w_right_vld),
            .i_right_load (w_right_load),
            .i_right_idx  (w_right_idx),
            .o_vld        (w_bin_vld[g]),
            .o_load       (w_bin_load[g]),
            .o_idx        (w_bin_idx[g]),
            .o_lt         (w_bin_lt[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_fire) begin
                    if (!w_full) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last_item) begin
                        n_state = ST_ASSIGN;
                    end
                end
            end
            ST_ASSIGN: begin
                if (w_step) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_bin_count <= BIN_COUNT_RST;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_bin_count <= i_cfg_wdata;
            end
            if (w_step) begin
                r_out_vld  <= 1'b1;
                r_out_id   <= w_item[0].id;
                r_out_bin  <= BIN_OUT_W'(w_bin_idx[0]);
                r_out_last <= (r_count == CNT_W'(1));
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_out_item_id = r_out_id;
    assign o_bin_index   = r_out_bin;
    assign o_last_result = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("item count above capacity");

    a_head_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ASSIGN) |-> (w_item[0].vld && w_bin_vld[0]))
        else $error("assignment with empty chain head");

    a_set_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && (r_count == CNT_W'(1))) |=> (!w_item[0].vld && (r_count == '0)))
        else $error("items left in chain after last result");

endmodule
